@@ src/cjdm_pkg.sv @@
// shared types, constants and codes for the cycle jitter deadline monitor
package cjdm_pkg;

    // field widths
    localparam int TIME_W      = 48;
    localparam int PERIOD_W    = 16;
    localparam int WARM_W      = 20;
    localparam int THR_W       = 16;
    localparam int IVL_W       = 20;
    localparam int GLITCH_W    = 32;
    localparam int EXTRA_W     = 8;
    localparam int DUR_W       = 32;
    localparam int JIT_W       = 16;
    localparam int CNT32_W     = 32;
    localparam int STREAK_W    = 17;
    localparam int WARMCNT_W   = WARM_W + 1;
    localparam int NUM_PHASES  = 6;
    localparam int PH_IDX_W    = 3;
    localparam int DIV_STEPS   = GLITCH_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int USER_W      = 3;

    // result flag positions in tuser
    localparam int USER_GLITCH = 0;
    localparam int USER_FAULT  = 1;
    localparam int USER_REPORT = 2;

    localparam logic [STREAK_W-1:0] STREAK_MAX = '1;

    // register reset values
    localparam logic [PERIOD_W-1:0] RST_PERIOD   = 16'd1000;
    localparam logic [WARM_W-1:0]   RST_WARMUP   = 20'd2000;
    localparam logic [THR_W-1:0]    RST_MISS_THR = 16'd200;
    localparam logic [IVL_W-1:0]    RST_IVL      = 20'd5000;
    localparam logic [GLITCH_W-1:0] RST_GLITCH   = 32'd1000000;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_PERIOD     = 3'd0,
        CFG_WARMUP     = 3'd1,
        CFG_MISS_THR   = 3'd2,
        CFG_REPORT_IVL = 3'd3,
        CFG_GLITCH     = 3'd4
    } t_cfg_reg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_JIT_A,
        S_JIT_B,
        S_GLITCH,
        S_JPER,
        S_DIV,
        S_EXPA,
        S_EXPB,
        S_PHASE,
        S_EXEC,
        S_EXPK,
        S_MISS,
        S_IOMAX,
        S_DONE
    } t_state;

    // input item, start_time in the low bits
    typedef struct packed {
        logic [DUR_W-1:0]   dur_diag;
        logic [DUR_W-1:0]   dur_events;
        logic [DUR_W-1:0]   dur_automation;
        logic [DUR_W-1:0]   dur_fieldbus;
        logic [DUR_W-1:0]   dur_io_apply;
        logic [DUR_W-1:0]   dur_io;
        logic [EXTRA_W-1:0] extra_ticks;
        logic [TIME_W-1:0]  end_time;
        logic [TIME_W-1:0]  start_time;
    } t_in_item;

    // result payload, worst_jitter in the low bits
    typedef struct packed {
        logic [DUR_W-1:0]   diag_peak;
        logic [DUR_W-1:0]   events_peak;
        logic [DUR_W-1:0]   automation_peak;
        logic [DUR_W-1:0]   fieldbus_peak;
        logic [DUR_W-1:0]   io_peak;
        logic [CNT32_W-1:0] overrun_total;
        logic [CNT32_W-1:0] miss_total;
        logic [TIME_W-1:0]  worst_exec;
        logic [JIT_W-1:0]   worst_jitter;
    } t_out_data;

    localparam int IN_W  = $bits(t_in_item);
    localparam int OUT_W = $bits(t_out_data);

    // shared add/subtract unit request and response
    typedef struct packed {
        logic              sub;
        logic [TIME_W-1:0] a;
        logic [TIME_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic              borrow;
        logic [TIME_W-1:0] res;
    } t_alu_rsp;

endpackage

@@ src/cycle_jitter_deadline_monitor_top.sv @@
// top level of the cycle jitter deadline monitor: sequencer, state and stream ports
//
// One transaction on the slave stream describes one cycle of a periodic control loop
// (start and end timestamps, extra ticks, six phase durations); for each one the block
// sends exactly one transaction on the master stream. tuser carries the flags glitch
// skipped, fault and report valid; when report valid is low every tdata field is zero.
// Items are processed one at a time by a small sequencer around a single 48-bit
// add/subtract unit: timestamp differences, the anchor advance, the glitch, period
// and deadline compares and all peak compares but the jitter one are steps on it,
// the six phase maxima are visited one per cycle, and the drift correction takes the
// remainder of the lateness by the period one bit per cycle over its 32 bits. An item
// occupies the block from acceptance to readiness for the next; tready stays low
// meanwhile, and the last step also waits for the output register to be free. A
// finished result sits in the output register, so the next item is accepted while it
// waits to be taken. Registers are written on the cfg channel (always ready); the
// user must write them only while the block is idle, the block does not enforce it;
// a zero period or report interval behaves as one. After reset the timing is not
// anchored: the first start timestamp becomes the expected time.
module cycle_jitter_deadline_monitor_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // start_time, end_time, extra_ticks, dur_io, dur_io_apply, dur_fieldbus,
    // dur_automation, dur_events, dur_diag
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [cjdm_pkg::IN_W-1:0]           s_axis_tdata,
    // worst_jitter, worst_exec, miss_total, overrun_total, io_peak, fieldbus_peak,
    // automation_peak, events_peak, diag_peak
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [cjdm_pkg::OUT_W-1:0]          m_axis_tdata,
    // glitch_skipped, fault, report_valid
    output logic [cjdm_pkg::USER_W-1:0]         m_axis_tuser,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [cjdm_pkg::CFG_ADDR_W-1:0]     i_cfg_index,
    input  logic [cjdm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import cjdm_pkg::*;

    // configuration registers
    logic [PERIOD_W-1:0] r_period;
    logic [WARM_W-1:0]   r_warmup;
    logic [THR_W-1:0]    r_thr;
    logic [IVL_W-1:0]    r_ivl;
    logic [GLITCH_W-1:0] r_glitch;

    // sequencer
    t_state r_state, n_state;
    t_alu_req alu_req;
    t_alu_rsp alu_rsp;

    // monitor state
    logic [TIME_W-1:0]    r_exp;
    logic [WARMCNT_W-1:0] r_wc;
    logic [IVL_W-1:0]     r_rc;
    logic [JIT_W-1:0]     r_jpk;
    logic                 r_have;
    logic [TIME_W-1:0]    r_epk;
    logic [CNT32_W-1:0]   r_miss;
    logic [STREAK_W-1:0]  r_streak;
    logic [CNT32_W-1:0]   r_ovr;
    logic [DUR_W-1:0]     r_ppk [NUM_PHASES];
    logic                 r_fault;

    // per-item control
    logic                 r_skip;
    logic                 r_res_fault;
    logic                 r_tick;
    logic                 r_lt;
    logic                 r_gt;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [PH_IDX_W-1:0]  r_idx;

    // per-item payload
    logic [TIME_W-1:0]    r_start;
    logic [TIME_W-1:0]    r_end;
    logic [DUR_W-1:0]     r_dur [NUM_PHASES];
    logic [TIME_W-1:0]    r_tmp;
    logic [TIME_W-1:0]    r_jit;
    logic [PERIOD_W-1:0]  r_rem;
    logic [GLITCH_W-1:0]  r_dvd;
    logic [TIME_W-1:0]    r_execv;
    logic [DUR_W-1:0]     r_iomax;

    // output register
    logic                 r_m_valid;
    logic [OUT_W-1:0]     r_m_data;
    logic [USER_W-1:0]    r_m_user;

    t_in_item             in_item;
    t_out_data            out_data;
    logic                 in_acc;
    logic                 out_free;
    logic                 report;
    logic [PERIOD_W-1:0]  period_eff;
    logic [IVL_W-1:0]     ivl_eff;
    logic [TIME_W-1:0]    period_x;
    logic [PERIOD_W:0]    div_trial;
    logic [IVL_W:0]       rc_inc;
    logic                 rc_tick;
    logic [STREAK_W-1:0]  streak_inc;

    assign in_item    = t_in_item'(s_axis_tdata);
    assign in_acc     = s_axis_tvalid && s_axis_tready;
    assign out_free   = !r_m_valid || m_axis_tready;
    assign period_eff = (r_period == '0) ? PERIOD_W'(1) : r_period;
    assign ivl_eff    = (r_ivl == '0) ? IVL_W'(1) : r_ivl;
    assign period_x   = TIME_W'(period_eff);
    // next remainder candidate: shift in the next dividend bit
    assign div_trial  = {r_rem, r_dvd[GLITCH_W-1]};
    assign rc_inc     = {1'b0, r_rc} + (IVL_W+1)'(1);
    assign rc_tick    = rc_inc >= {1'b0, ivl_eff};
    assign streak_inc = (r_streak != STREAK_MAX) ? r_streak + STREAK_W'(1) : r_streak;
    // a report needs a tick, samples, and neither a glitch nor a fault on this item
    assign report     = r_tick && r_have && !r_skip && !r_res_fault;

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

    cjdm_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= RST_PERIOD;
            r_warmup <= RST_WARMUP;
            r_thr    <= RST_MISS_THR;
            r_ivl    <= RST_IVL;
            r_glitch <= RST_GLITCH;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_PERIOD:     r_period <= i_cfg_data[PERIOD_W-1:0];
                CFG_WARMUP:     r_warmup <= i_cfg_data[WARM_W-1:0];
                CFG_MISS_THR:   r_thr    <= i_cfg_data[THR_W-1:0];
                CFG_REPORT_IVL: r_ivl    <= i_cfg_data[IVL_W-1:0];
                CFG_GLITCH:     r_glitch <= i_cfg_data[GLITCH_W-1:0];
                default: ;
            endcase
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and operand selection for the shared unit
    always_comb begin
        n_state     = r_state;
        alu_req.sub = 1'b1;
        alu_req.a   = '0;
        alu_req.b   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = r_fault ? S_DONE : S_JIT_A;
                end
            end
            S_JIT_A: begin
                // start - expected
                alu_req.a = r_start;
                alu_req.b = r_exp;
                n_state   = S_JIT_B;
            end
            S_JIT_B: begin
                // expected - start
                alu_req.a = r_exp;
                alu_req.b = r_start;
                n_state   = S_GLITCH;
            end
            S_GLITCH: begin
                // borrow means jitter above the glitch limit
                alu_req.a = TIME_W'(r_glitch);
                alu_req.b = r_jit;
                n_state   = alu_rsp.borrow ? S_EXPB : S_JPER;
            end
            S_JPER: begin
                alu_req.a = r_jit;
                alu_req.b = period_x;
                n_state   = r_gt ? S_DIV : S_EXPB;
            end
            S_DIV: begin
                alu_req.a = TIME_W'(div_trial);
                alu_req.b = period_x;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_EXPA;
                end
            end
            S_EXPA: begin
                // start minus lateness remainder lands on the period grid
                alu_req.a = r_start;
                alu_req.b = TIME_W'(r_rem);
                n_state   = S_EXPB;
            end
            S_EXPB: begin
                alu_req.sub = 1'b0;
                alu_req.a   = r_exp;
                alu_req.b   = period_x;
                n_state     = r_skip ? S_DONE : S_PHASE;
            end
            S_PHASE: begin
                alu_req.a = TIME_W'(r_ppk[r_idx]);
                alu_req.b = TIME_W'(r_dur[r_idx]);
                if (r_idx == PH_IDX_W'(NUM_PHASES - 1)) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                alu_req.a = r_end;
                alu_req.b = r_start;
                n_state   = S_EXPK;
            end
            S_EXPK: begin
                alu_req.a = r_epk;
                alu_req.b = r_execv;
                n_state   = S_MISS;
            end
            S_MISS: begin
                // borrow means execution time past the deadline
                alu_req.a = period_x;
                alu_req.b = r_execv;
                n_state   = S_IOMAX;
            end
            S_IOMAX: begin
                alu_req.a = TIME_W'(r_ppk[0]);
                alu_req.b = TIME_W'(r_ppk[1]);
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // monitor state and per-item control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp       <= '0;
            r_wc        <= '0;
            r_rc        <= '0;
            r_jpk       <= '0;
            r_have      <= 1'b0;
            r_epk       <= '0;
            r_miss      <= '0;
            r_streak    <= '0;
            r_ovr       <= '0;
            r_fault     <= 1'b0;
            r_skip      <= 1'b0;
            r_res_fault <= 1'b0;
            r_tick      <= 1'b0;
            r_lt        <= 1'b0;
            r_gt        <= 1'b0;
            r_cnt       <= '0;
            r_idx       <= '0;
            r_m_valid   <= 1'b0;
            for (int i = 0; i < NUM_PHASES; i++) begin
                r_ppk[i] <= '0;
            end
        end else begin
            if (r_state == S_DONE && out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_skip      <= 1'b0;
                        r_tick      <= 1'b0;
                        r_res_fault <= r_fault;
                        if (!r_fault) begin
                            r_ovr <= r_ovr + CNT32_W'(in_item.extra_ticks);
                            // not anchored yet: take this start as the expected time
                            if (r_exp == '0) begin
                                r_exp <= in_item.start_time;
                            end
                        end
                    end
                end
                S_JIT_A: begin
                    r_lt <= alu_rsp.borrow;
                    r_gt <= !alu_rsp.borrow && (alu_rsp.res != '0);
                end
                S_GLITCH: begin
                    if (alu_rsp.borrow) begin
                        // re-anchor; the period is added in the shared step
                        r_exp  <= r_start;
                        r_skip <= 1'b1;
                    end else begin
                        if (r_wc <= WARMCNT_W'(r_warmup)) begin
                            r_wc <= r_wc + WARMCNT_W'(1);
                        end
                        r_rc   <= rc_tick ? '0 : rc_inc[IVL_W-1:0];
                        r_tick <= rc_tick;
                    end
                end
                S_JPER: begin
                    r_cnt <= '0;
                    if (r_wc > WARMCNT_W'(r_warmup) && alu_rsp.borrow) begin
                        r_have <= 1'b1;
                        // jitter below the period fits the peak width
                        if (r_jit[JIT_W-1:0] > r_jpk) begin
                            r_jpk <= r_jit[JIT_W-1:0];
                        end
                    end
                end
                S_DIV: begin
                    r_cnt <= r_cnt + DIV_CNT_W'(1);
                end
                S_EXPA: begin
                    r_exp <= alu_rsp.res;
                end
                S_EXPB: begin
                    r_exp <= alu_rsp.res;
                    r_idx <= '0;
                end
                S_PHASE: begin
                    if (alu_rsp.borrow) begin
                        r_ppk[r_idx] <= r_dur[r_idx];
                    end
                    r_idx <= r_idx + PH_IDX_W'(1);
                end
                S_EXPK: begin
                    if (alu_rsp.borrow) begin
                        r_epk <= r_execv;
                    end
                end
                S_MISS: begin
                    if (alu_rsp.borrow) begin
                        r_miss   <= r_miss + CNT32_W'(1);
                        r_streak <= streak_inc;
                        if (streak_inc > STREAK_W'(r_thr)) begin
                            r_fault     <= 1'b1;
                            r_res_fault <= 1'b1;
                        end
                    end else begin
                        r_streak <= '0;
                    end
                end
                S_DONE: begin
                    // window maxima clear once reported
                    if (out_free && report) begin
                        r_jpk  <= '0;
                        r_have <= 1'b0;
                        r_epk  <= '0;
                        for (int i = 0; i < NUM_PHASES; i++) begin
                            r_ppk[i] <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // result payload
    always_comb begin
        out_data = '0;
        if (report) begin
            out_data.worst_jitter    = r_jpk;
            out_data.worst_exec      = r_epk;
            out_data.miss_total      = r_miss;
            out_data.overrun_total   = r_ovr;
            out_data.io_peak         = r_iomax;
            out_data.fieldbus_peak   = r_ppk[2];
            out_data.automation_peak = r_ppk[3];
            out_data.events_peak     = r_ppk[4];
            out_data.diag_peak       = r_ppk[5];
        end
    end

    // item payload and working values
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_start  <= in_item.start_time;
                    r_end    <= in_item.end_time;
                    r_dur[0] <= in_item.dur_io;
                    r_dur[1] <= in_item.dur_io_apply;
                    r_dur[2] <= in_item.dur_fieldbus;
                    r_dur[3] <= in_item.dur_automation;
                    r_dur[4] <= in_item.dur_events;
                    r_dur[5] <= in_item.dur_diag;
                end
            end
            S_JIT_A: r_tmp <= alu_rsp.res;
            S_JIT_B: r_jit <= r_lt ? alu_rsp.res : r_tmp;
            S_JPER: begin
                // lateness stays within the glitch limit width here
                r_dvd <= r_jit[GLITCH_W-1:0];
                r_rem <= '0;
            end
            S_DIV: begin
                r_rem <= alu_rsp.borrow ? div_trial[PERIOD_W-1:0]
                                        : alu_rsp.res[PERIOD_W-1:0];
                r_dvd <= r_dvd << 1;
            end
            S_EXEC:  r_execv <= alu_rsp.borrow ? '0 : alu_rsp.res;
            S_IOMAX: r_iomax <= alu_rsp.borrow ? r_ppk[1] : r_ppk[0];
            S_DONE: begin
                if (out_free) begin
                    r_m_data              <= out_data;
                    r_m_user              <= '0;
                    r_m_user[USER_GLITCH] <= r_skip;
                    r_m_user[USER_FAULT]  <= r_res_fault;
                    r_m_user[USER_REPORT] <= report;
                end
            end
            default: ;
        endcase
    end

    // the fault never clears once latched
    a_fault_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fault |=> r_fault)
        else $error("latched fault cleared");

    // a report never comes with a glitch or fault flag
    a_report_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[USER_REPORT])
            |-> (!m_axis_tuser[USER_FAULT] && !m_axis_tuser[USER_GLITCH]))
        else $error("report combined with glitch or fault");

    // without a report the payload is all zero
    a_quiet_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[USER_REPORT]) |-> (m_axis_tdata == '0))
        else $error("payload set without report");

    // the serial remainder ends below the period
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXPA) |-> (r_rem < period_eff))
        else $error("remainder not below period");

endmodule

@@ src/cjdm_alu.sv @@
// shared add/subtract unit with borrow flag, used by the sequencer steps between acceptance and the result
module cjdm_alu (
    input  cjdm_pkg::t_alu_req i_req,
    output cjdm_pkg::t_alu_rsp o_rsp
);
    import cjdm_pkg::*;

    logic [TIME_W-1:0] b_op;
    logic [TIME_W:0]   sum;

    assign b_op = i_req.sub ? ~i_req.b : i_req.b;
    assign sum  = {1'b0, i_req.a} + {1'b0, b_op} + {{TIME_W{1'b0}}, i_req.sub};

    assign o_rsp.res    = sum[TIME_W-1:0];
    // borrow on subtract (a < b), carry out on add
    assign o_rsp.borrow = i_req.sub ? ~sum[TIME_W] : sum[TIME_W];

endmodule
